// File: rtl/core/pcs_pkg.sv
// shared constants for the percentile contrast stretch block
package pcs_pkg;

    // frame store geometry
    localparam int FRAME_PIXELS = 4096;
    localparam int FRAME_AW     = $clog2(FRAME_PIXELS);

    // field widths
    localparam int PIX_W   = 8;
    localparam int IDX_W   = 12;
    localparam int BIN_W   = 13;
    localparam int BINS    = 256;
    localparam int ACC_W   = BIN_W + $clog2(BINS);
    localparam int SCALE_W = 16;

    localparam logic [BIN_W-1:0]   BIN_MAX   = 13'd8191;
    localparam logic [SCALE_W-1:0] SCALE_NUM = 16'd65280;

    // divider
    localparam int DIV_STEPS = SCALE_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_PCT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE = 2'd2;

    localparam logic [BIN_W-1:0] RST_PCT_COUNT = 13'd40;
    localparam logic [PIX_W-1:0] RST_MIN_RANGE = 8'd20;
    localparam logic [PIX_W-1:0] RST_MAX_RANGE = 8'd200;

    // item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_READ = 1'b1;

endpackage

// File: rtl/core/percentile_contrast_stretch.sv
// percentile contrast stretch: frame store, histogram, level scan, divider and pixel mapper
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------------------
//  in      | sink      | in_valid / in_stall | kind, pixel, index
//  out     | source    | out_valid/out_stall | pixel_out, low_level, high_level, stretched
//  cfg     | sink      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  a load beat is accepted, then its histogram bin is read and written back
//  a read beat is accepted, reads the frame store, is mapped and may wait on the output register
//  first read of a frame adds a low and a high scan, a guard step, the divide if stretched
//  reset clears control and histogram valid bits, presets levels, config; no clearing pass
//  in_stall is high whenever the sequencer is busy; a finished result waits in the
//  output register while the next beat is taken
module percentile_contrast_stretch
(
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               kind,
    input  logic [pcs_pkg::PIX_W-1:0]          pixel,
    input  logic [pcs_pkg::IDX_W-1:0]          index,

    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [pcs_pkg::PIX_W-1:0]          pixel_out,
    output logic [pcs_pkg::PIX_W-1:0]          low_level,
    output logic [pcs_pkg::PIX_W-1:0]          high_level,
    output logic                               stretched,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pcs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pcs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // sequencer states
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_LD_RD   = 3'd1;   // histogram bin read for a load
    localparam logic [2:0] ST_LD_WR   = 3'd2;   // bin increment and write back
    localparam logic [2:0] ST_SCAN_LO = 3'd3;   // scan from bin 0 upwards
    localparam logic [2:0] ST_SCAN_HI = 3'd4;   // scan from bin 255 downwards
    localparam logic [2:0] ST_GUARD   = 3'd5;   // range check, divider set-up
    localparam logic [2:0] ST_DIV     = 3'd6;   // one quotient bit per cycle
    localparam logic [2:0] ST_RD_MEM  = 3'd7;   // frame store read

    // the mapping state shares no code space with the above, so keep a flag
    // for "read data present, map and hand to the output register"

    localparam int SCAN_CNT_W = $clog2(pcs_pkg::BINS) + 1;
    localparam logic [SCAN_CNT_W-1:0] SCAN_LAST = SCAN_CNT_W'(pcs_pkg::BINS);

    logic [2:0]                         state_reg, state_next;
    logic                               map_reg, map_next;

    // configuration
    logic [pcs_pkg::BIN_W-1:0]          pct_reg;
    logic [pcs_pkg::PIX_W-1:0]          min_reg;
    logic [pcs_pkg::PIX_W-1:0]          max_reg;

    // frame level state
    logic                               reading_reg, reading_next;
    logic [pcs_pkg::PIX_W-1:0]          low_reg, low_next;
    logic [pcs_pkg::PIX_W-1:0]          high_reg, high_next;
    logic [pcs_pkg::SCALE_W-1:0]        scale_reg, scale_next;
    logic                               stretch_reg, stretch_next;

    // latched beat
    logic [pcs_pkg::PIX_W-1:0]          pix_reg;
    logic [pcs_pkg::IDX_W-1:0]          idx_reg;
    logic                               in_frame_reg;

    // scan
    logic [SCAN_CNT_W-1:0]              cnt_reg, cnt_next;
    logic [pcs_pkg::ACC_W-1:0]          acc_reg, acc_next;
    logic                               found_reg, found_next;

    // divider
    logic [pcs_pkg::PIX_W-1:0]          div_den_reg, div_den_next;
    logic [pcs_pkg::PIX_W-1:0]          div_rem_reg, div_rem_next;
    logic [pcs_pkg::SCALE_W-1:0]        div_q_reg, div_q_next;
    logic [pcs_pkg::DIV_CNT_W-1:0]      div_cnt_reg, div_cnt_next;

    // output register
    logic                               out_valid_reg;
    logic [pcs_pkg::PIX_W-1:0]          pixel_out_reg;
    logic [pcs_pkg::PIX_W-1:0]          low_level_reg;
    logic [pcs_pkg::PIX_W-1:0]          high_level_reg;
    logic                               stretched_reg;

    // memories
    logic [pcs_pkg::PIX_W-1:0]          frame_mem [pcs_pkg::FRAME_PIXELS];
    logic [pcs_pkg::PIX_W-1:0]          frame_rd_reg;
    logic [pcs_pkg::BIN_W-1:0]          hist_mem [pcs_pkg::BINS];
    logic [pcs_pkg::BINS-1:0]           hist_vld_reg;
    logic [pcs_pkg::BIN_W-1:0]          hist_rd_reg;
    logic                               hist_rvld_reg;

    // handshakes
    logic                               in_acc;
    logic                               out_acc;
    logic                               out_free;
    logic                               cfg_wr;
    logic                               in_frame;

    // datapath nets
    logic [pcs_pkg::PIX_W-1:0]          hist_raddr;
    logic [pcs_pkg::BIN_W-1:0]          hist_data;
    logic [pcs_pkg::BIN_W-1:0]          hist_inc;
    logic                               hist_we;
    logic                               hist_clr;
    logic                               frame_we;
    logic                               frame_re;
    logic [pcs_pkg::FRAME_AW-1:0]       frame_addr;

    logic [SCAN_CNT_W-1:0]              cnt_m1;
    logic [pcs_pkg::PIX_W-1:0]          scan_bin;
    logic [pcs_pkg::PIX_W-1:0]          scan_addr;
    logic                               scan_chk;
    logic [pcs_pkg::ACC_W-1:0]          acc_sum;
    logic                               scan_hit;

    logic [pcs_pkg::PIX_W:0]            range9;
    logic                               range_skip;

    logic [pcs_pkg::PIX_W:0]            rem_sh;
    logic                               rem_ge;

    logic [pcs_pkg::PIX_W-1:0]          map_diff;
    logic [pcs_pkg::PIX_W+pcs_pkg::SCALE_W-1:0] map_prod;
    logic [pcs_pkg::PIX_W-1:0]          map_pix;

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    assign in_stall  = (state_reg != ST_IDLE) || map_reg;
    assign in_acc    = in_valid && !in_stall;
    assign out_acc   = out_valid_reg && !out_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = (state_reg == ST_IDLE) && !map_reg;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // pixels past the frame never touch the store
    assign in_frame  = (32'(index) < pcs_pkg::FRAME_PIXELS);

    // ------------------------------------------------------------------
    // scan datapath: one bin read issued per cycle, checked the cycle after
    // ------------------------------------------------------------------
    assign cnt_m1    = cnt_reg - SCAN_CNT_W'(1);
    assign scan_chk  = (cnt_reg != '0);
    assign scan_bin  = (state_reg == ST_SCAN_HI) ? ~cnt_m1[pcs_pkg::PIX_W-1:0]
                                                 :  cnt_m1[pcs_pkg::PIX_W-1:0];
    assign scan_addr = (state_reg == ST_SCAN_HI) ? ~cnt_reg[pcs_pkg::PIX_W-1:0]
                                                 :  cnt_reg[pcs_pkg::PIX_W-1:0];

    // an entry not yet written this frame reads as an empty bin
    assign hist_data = hist_rvld_reg ? hist_rd_reg : '0;
    assign acc_sum   = acc_reg + pcs_pkg::ACC_W'(hist_data);
    assign scan_hit  = scan_chk && !found_reg && (acc_sum >= pcs_pkg::ACC_W'(pct_reg));

    assign hist_raddr = (state_reg == ST_LD_RD) ? pix_reg : scan_addr;

    // saturating bin count
    assign hist_inc  = (hist_data < pcs_pkg::BIN_MAX) ? hist_data + 1'b1 : hist_data;
    assign hist_we   = (state_reg == ST_LD_WR);
    // a load after reads opens a new frame
    assign hist_clr  = in_acc && (kind == pcs_pkg::KIND_LOAD) && reading_reg;

    assign frame_addr = pcs_pkg::FRAME_AW'(idx_reg);
    assign frame_we   = (state_reg == ST_LD_RD) && in_frame_reg;
    assign frame_re   = (state_reg == ST_RD_MEM);

    // ------------------------------------------------------------------
    // range guard and divider step
    // ------------------------------------------------------------------
    assign range9     = {1'b0, high_reg} - {1'b0, low_reg};
    assign range_skip = range9[pcs_pkg::PIX_W] || (range9 == '0)
                     || (range9[pcs_pkg::PIX_W-1:0] > max_reg)
                     || (range9[pcs_pkg::PIX_W-1:0] < min_reg);

    // restoring division, remainder stays below the divisor
    assign rem_sh = {div_rem_reg, div_q_reg[pcs_pkg::SCALE_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, div_den_reg});

    // ------------------------------------------------------------------
    // pixel mapping
    // ------------------------------------------------------------------
    assign map_diff = frame_rd_reg - low_reg;
    assign map_prod = (pcs_pkg::PIX_W + pcs_pkg::SCALE_W)'(map_diff)
                    * (pcs_pkg::PIX_W + pcs_pkg::SCALE_W)'(scale_reg);

    always_comb
    begin
        if (!in_frame_reg)
            map_pix = '0;
        else if (!stretch_reg)
            map_pix = frame_rd_reg;
        else if (frame_rd_reg <= low_reg)
            map_pix = '0;
        else if (frame_rd_reg >= high_reg)
            map_pix = '1;
        else
            map_pix = map_prod[pcs_pkg::PIX_W +: pcs_pkg::PIX_W];
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next   = state_reg;
        map_next     = map_reg;
        reading_next = reading_reg;
        low_next     = low_reg;
        high_next    = high_reg;
        scale_next   = scale_reg;
        stretch_next = stretch_reg;
        cnt_next     = cnt_reg;
        acc_next     = acc_reg;
        found_next   = found_reg;
        div_den_next = div_den_reg;
        div_rem_next = div_rem_reg;
        div_q_next   = div_q_reg;
        div_cnt_next = div_cnt_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (map_reg)
                begin
                    // hold the mapped beat until the output register frees up
                    if (out_free)
                        map_next = 1'b0;
                end
                else if (in_acc)
                begin
                    if (kind == pcs_pkg::KIND_LOAD)
                    begin
                        reading_next = 1'b0;
                        state_next   = in_frame ? ST_LD_RD : ST_IDLE;
                    end
                    else if (!reading_reg)
                    begin
                        // first read of the frame: find the levels
                        reading_next = 1'b1;
                        low_next     = '0;
                        high_next    = '1;
                        cnt_next     = '0;
                        acc_next     = '0;
                        found_next   = 1'b0;
                        state_next   = ST_SCAN_LO;
                    end
                    else
                    begin
                        state_next = ST_RD_MEM;
                    end
                end
            end

            ST_LD_RD:
            begin
                state_next = ST_LD_WR;
            end

            ST_LD_WR:
            begin
                state_next = ST_IDLE;
            end

            ST_SCAN_LO,
            ST_SCAN_HI:
            begin
                cnt_next = cnt_reg + SCAN_CNT_W'(1);
                if (scan_chk)
                    acc_next = acc_sum;
                if (scan_hit)
                begin
                    found_next = 1'b1;
                    if (state_reg == ST_SCAN_HI)
                        high_next = scan_bin;
                    else
                        low_next = scan_bin;
                end
                if (cnt_reg == SCAN_LAST)
                begin
                    cnt_next   = '0;
                    acc_next   = '0;
                    found_next = 1'b0;
                    state_next = (state_reg == ST_SCAN_LO) ? ST_SCAN_HI : ST_GUARD;
                end
            end

            ST_GUARD:
            begin
                if (range_skip)
                begin
                    stretch_next = 1'b0;
                    scale_next   = '0;
                    state_next   = ST_RD_MEM;
                end
                else
                begin
                    div_den_next = range9[pcs_pkg::PIX_W-1:0];
                    div_rem_next = '0;
                    div_q_next   = pcs_pkg::SCALE_NUM;
                    div_cnt_next = '0;
                    state_next   = ST_DIV;
                end
            end

            ST_DIV:
            begin
                div_rem_next = rem_ge ? pcs_pkg::PIX_W'(rem_sh - {1'b0, div_den_reg})
                                      : pcs_pkg::PIX_W'(rem_sh);
                div_q_next   = {div_q_reg[pcs_pkg::SCALE_W-2:0], rem_ge};
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == pcs_pkg::DIV_CNT_W'(pcs_pkg::DIV_STEPS - 1))
                begin
                    scale_next   = {div_q_reg[pcs_pkg::SCALE_W-2:0], rem_ge};
                    stretch_next = 1'b1;
                    state_next   = ST_RD_MEM;
                end
            end

            ST_RD_MEM:
            begin
                map_next   = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            map_reg     <= 1'b0;
            reading_reg <= 1'b0;
            low_reg     <= '0;
            high_reg    <= '1;
            scale_reg   <= '0;
            stretch_reg <= 1'b0;
            cnt_reg     <= '0;
            found_reg   <= 1'b0;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            map_reg     <= map_next;
            reading_reg <= reading_next;
            low_reg     <= low_next;
            high_reg    <= high_next;
            scale_reg   <= scale_next;
            stretch_reg <= stretch_next;
            cnt_reg     <= cnt_next;
            found_reg   <= found_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        div_den_reg <= div_den_next;
        div_rem_reg <= div_rem_next;
        div_q_reg   <= div_q_next;
        if (in_acc)
        begin
            pix_reg      <= pixel;
            idx_reg      <= index;
            in_frame_reg <= in_frame;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pct_reg <= pcs_pkg::RST_PCT_COUNT;
            min_reg <= pcs_pkg::RST_MIN_RANGE;
            max_reg <= pcs_pkg::RST_MAX_RANGE;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                pcs_pkg::REG_PCT_COUNT: pct_reg <= cfg_data;
                pcs_pkg::REG_MIN_RANGE: min_reg <= cfg_data[pcs_pkg::PIX_W-1:0];
                pcs_pkg::REG_MAX_RANGE: max_reg <= cfg_data[pcs_pkg::PIX_W-1:0];
                default:                ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // memories
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (frame_we)
            frame_mem[frame_addr] <= pix_reg;
        if (frame_re)
            frame_rd_reg <= frame_mem[frame_addr];
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist_mem[pix_reg] <= hist_inc;
        hist_rd_reg <= hist_mem[hist_raddr];
    end

    // per-bin valid bits stand in for clearing the histogram
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_vld_reg  <= '0;
            hist_rvld_reg <= 1'b0;
        end
        else
        begin
            hist_rvld_reg <= hist_vld_reg[hist_raddr];
            if (hist_clr)
                hist_vld_reg <= '0;
            else if (hist_we)
                hist_vld_reg[pix_reg] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (map_reg && out_free)
            out_valid_reg <= 1'b1;
        else if (out_acc)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (map_reg && out_free)
        begin
            pixel_out_reg  <= map_pix;
            low_level_reg  <= low_reg;
            high_level_reg <= high_reg;
            stretched_reg  <= stretch_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_out  = pixel_out_reg;
    assign low_level  = low_level_reg;
    assign high_level = high_level_reg;
    assign stretched  = stretched_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // a result only appears after a mapped frame store read
    a_out_from_map: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(map_reg))
        else $error("result raised without a mapped read");

    // a stretched beat always carries an ordered pair of levels
    a_stretch_levels: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && stretched_reg) |-> (low_level_reg < high_level_reg))
        else $error("stretched beat with crossed levels");

    // the divider never runs on an empty range
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (div_den_reg != '0))
        else $error("divider started with zero range");

    // the histogram port is never written while a scan is under way
    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN_LO) || (state_reg == ST_SCAN_HI)) |=> !$past(hist_we))
        else $error("histogram written during level scan");

endmodule

// File: bench/tb.sv
// self-checking testbench for the percentile contrast stretch block
`timescale 1ns / 1ps

module tb;

    // cycles of no accepted beat on any channel before the run is abandoned
    localparam int HANG_LIMIT    = 5000;
    // the first read of a frame scans the histogram twice and may divide
    localparam int SETTLE_CYCLES = 600;
    localparam int RANDOM_ITEMS  = 1000;
    localparam int SHOWN_ERRORS  = 10;
    localparam logic [pcs_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_READ} row_op_t;

    typedef struct packed {
        logic [pcs_pkg::PIX_W-1:0] pix_out;
        logic [pcs_pkg::PIX_W-1:0] low;
        logic [pcs_pkg::PIX_W-1:0] high;
        logic                      stretched;
    } result_t;

    // one line of the directed stimulus list
    typedef struct packed {
        row_op_t                        op;
        logic [pcs_pkg::CFG_IDX_W-1:0]  reg_sel;
        logic [pcs_pkg::CFG_DATA_W-1:0] reg_val;
        logic [pcs_pkg::PIX_W-1:0]      pix;
        logic [pcs_pkg::IDX_W-1:0]      idx;
        logic                           typed;
        result_t                        want;
    } row_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic                           kind = pcs_pkg::KIND_LOAD;
    logic [pcs_pkg::PIX_W-1:0]      pixel = '0;
    logic [pcs_pkg::IDX_W-1:0]      index = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [pcs_pkg::PIX_W-1:0]      pixel_out;
    logic [pcs_pkg::PIX_W-1:0]      low_level;
    logic [pcs_pkg::PIX_W-1:0]      high_level;
    logic                           stretched;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [pcs_pkg::CFG_IDX_W-1:0]  cfg_index = pcs_pkg::REG_PCT_COUNT;
    logic [pcs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    percentile_contrast_stretch uut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // bench copy of the block: register settings, frame, histogram and latched levels
    logic [pcs_pkg::BIN_W-1:0] cfg_pct_count = pcs_pkg::RST_PCT_COUNT;
    logic [pcs_pkg::PIX_W-1:0] cfg_min_range = pcs_pkg::RST_MIN_RANGE;
    logic [pcs_pkg::PIX_W-1:0] cfg_max_range = pcs_pkg::RST_MAX_RANGE;
    logic [pcs_pkg::PIX_W-1:0] frame_copy [0:pcs_pkg::FRAME_PIXELS-1];
    logic [pcs_pkg::BIN_W-1:0] bin_count [0:pcs_pkg::BINS-1];
    int               lvl_low = 0;
    int               lvl_high = 255;
    int               lvl_scale = 0;
    bit               stretch_en = 1'b0;
    bit               frame_closed = 1'b0;   // set once the first read has latched levels

    // read positions already loaded, so no read ever touches an unwritten pixel
    bit               px_written [0:pcs_pkg::FRAME_PIXELS-1];
    int               written_idx [$];

    result_t          pending_pixels [$];
    row_t             rows [$];

    int               fail_count = 0;
    int               results_checked = 0;
    int               loads_sent = 0;
    int               reads_sent = 0;
    int               hang_count = 0;
    int               send_idle_pct = 0;
    int               stall_pct = 0;

    initial
    begin
        foreach (bin_count[b]) bin_count[b] = '0;
        foreach (px_written[i]) px_written[i] = 1'b0;
    end

    // works out what one accepted beat produces and advances the bench copy
    task automatic predict_pixel(input logic k, input logic [pcs_pkg::PIX_W-1:0] p,
                                 input logic [pcs_pkg::IDX_W-1:0] ix,
                                 output bit has, output result_t r);
        int acc;
        int lo;
        int hi;
        int rng;
        int v;
        int b;
        bit hit;
        has = 1'b0;
        r = '0;
        if (k == pcs_pkg::KIND_LOAD)
        begin
            // a load after reads opens a new frame; pixels themselves are kept
            if (frame_closed)
            begin
                for (b = 0; b < pcs_pkg::BINS; b++) bin_count[b] = '0;
                frame_closed = 1'b0;
            end
            if (int'(ix) < pcs_pkg::FRAME_PIXELS)
            begin
                frame_copy[ix] = p;
                if (bin_count[p] < pcs_pkg::BIN_MAX) bin_count[p] = bin_count[p] + 1'b1;
            end
        end
        else
        begin
            if (!frame_closed)
            begin
                // low level: first bin from the dark end whose running total reaches the count
                acc = 0;
                lo = 0;
                hit = 1'b0;
                for (b = 0; b < pcs_pkg::BINS; b++)
                begin
                    if (!hit)
                    begin
                        acc += int'(bin_count[b]);
                        if (acc >= int'(cfg_pct_count))
                        begin
                            lo = b;
                            hit = 1'b1;
                        end
                    end
                end
                // high level: the same from the bright end
                acc = 0;
                hi = 255;
                hit = 1'b0;
                for (b = pcs_pkg::BINS - 1; b >= 0; b--)
                begin
                    if (!hit)
                    begin
                        acc += int'(bin_count[b]);
                        if (acc >= int'(cfg_pct_count))
                        begin
                            hi = b;
                            hit = 1'b1;
                        end
                    end
                end
                lvl_low = lo;
                lvl_high = hi;
                rng = hi - lo;
                // empty, crossed or out-of-guard range leaves pixels untouched
                if (rng <= 0 || rng > int'(cfg_max_range) || rng < int'(cfg_min_range))
                begin
                    stretch_en = 1'b0;
                    lvl_scale = 0;
                end
                else
                begin
                    stretch_en = 1'b1;
                    lvl_scale = (int'(pcs_pkg::SCALE_NUM) / rng) & 16'hFFFF;
                end
                frame_closed = 1'b1;
            end
            v = 0;
            if (int'(ix) < pcs_pkg::FRAME_PIXELS)
            begin
                v = int'(frame_copy[ix]);
                if (stretch_en)
                begin
                    if (v <= lvl_low)
                        v = 0;
                    else if (v >= lvl_high)
                        v = 255;
                    else
                        v = ((v - lvl_low) * lvl_scale) >> 8;
                end
            end
            r.pix_out = v[pcs_pkg::PIX_W-1:0];
            r.low = lvl_low[pcs_pkg::PIX_W-1:0];
            r.high = lvl_high[pcs_pkg::PIX_W-1:0];
            r.stretched = stretch_en;
            has = 1'b1;
        end
    endtask

    task automatic log_mismatch(input string what, input int want_v, input int got_v);
        fail_count++;
        if (fail_count <= SHOWN_ERRORS)
            $display("mismatch on %s at %0t: expected %0d, got %0d",
                     what, $realtime, want_v, got_v);
    endtask

    // one input beat, with random sender gaps in front of it
    task automatic send_item(input logic k, input logic [pcs_pkg::PIX_W-1:0] p,
                             input logic [pcs_pkg::IDX_W-1:0] ix,
                             input bit typed, input result_t want);
        bit      has;
        result_t calc;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        pixel    <= p;
        index    <= ix;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_pixel(k, p, ix, has, calc);
        if (has) pending_pixels.push_back(typed ? want : calc);
        if (k == pcs_pkg::KIND_LOAD)
        begin
            loads_sent++;
            if (!px_written[ix])
            begin
                px_written[ix] = 1'b1;
                written_idx.push_back(int'(ix));
            end
        end
        else
            reads_sent++;
    endtask

    task automatic write_reg(input logic [pcs_pkg::CFG_IDX_W-1:0] sel,
                             input logic [pcs_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (sel)
            pcs_pkg::REG_PCT_COUNT: cfg_pct_count = val[pcs_pkg::BIN_W-1:0];
            pcs_pkg::REG_MIN_RANGE: cfg_min_range = val[pcs_pkg::PIX_W-1:0];
            pcs_pkg::REG_MAX_RANGE: cfg_max_range = val[pcs_pkg::PIX_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // block idle: every result back, then room for a scan still running behind the loads
    task automatic settle_idle();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic add_cfg(input logic [pcs_pkg::CFG_IDX_W-1:0] sel, input int val);
        row_t t;
        t = '0;
        t.op = ROW_CFG;
        t.reg_sel = sel;
        t.reg_val = val[pcs_pkg::CFG_DATA_W-1:0];
        rows.push_back(t);
    endtask

    task automatic add_load(input int p, input int ix);
        row_t t;
        t = '0;
        t.op = ROW_LOAD;
        t.pix = p[pcs_pkg::PIX_W-1:0];
        t.idx = ix[pcs_pkg::IDX_W-1:0];
        rows.push_back(t);
    endtask

    task automatic add_read(input int ix, input int po, input int lo, input int hi,
                            input bit st);
        row_t t;
        t = '0;
        t.op = ROW_READ;
        t.idx = ix[pcs_pkg::IDX_W-1:0];
        t.pix = 8'hA5;                      // ignored on a read
        t.typed = 1'b1;
        t.want.pix_out = po[pcs_pkg::PIX_W-1:0];
        t.want.low = lo[pcs_pkg::PIX_W-1:0];
        t.want.high = hi[pcs_pkg::PIX_W-1:0];
        t.want.stretched = st;
        rows.push_back(t);
    endtask

    // output side: random stall, and every accepted result beat checked against the oldest
    // waiting expectation
    always @(posedge clk)
    begin
        result_t want;
        if (out_valid && !out_stall)
        begin
            if (pending_pixels.size() == 0)
                log_mismatch("result beat with nothing pending", -1, int'(pixel_out));
            else
            begin
                want = pending_pixels.pop_front();
                results_checked++;
                if (pixel_out !== want.pix_out)
                    log_mismatch("pixel_out", int'(want.pix_out), int'(pixel_out));
                if (low_level !== want.low)
                    log_mismatch("low_level", int'(want.low), int'(low_level));
                if (high_level !== want.high)
                    log_mismatch("high_level", int'(want.high), int'(high_level));
                if (stretched !== want.stretched)
                    log_mismatch("stretched", int'(want.stretched), int'(stretched));
            end
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // watchdog on all three channels
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            hang_count <= 0;
        else
            hang_count <= hang_count + 1;
        if (hang_count >= HANG_LIMIT)
        begin
            $display("watchdog: no beat accepted for %0d cycles", HANG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int       phase;
        int       frames_run;
        int       random_items;
        int       n_loads;
        int       n_reads;
        int       base;
        int       spread;
        int       tmp;
        int       sel;
        logic [pcs_pkg::PIX_W-1:0] p;
        logic [pcs_pkg::IDX_W-1:0] ix;
        bit       last_cfg;

        phase = 0;
        frames_run = 0;
        random_items = 0;
        last_cfg = 1'b0;

        // reset register values: one dim pixel, range 255 is over the default guard
        add_load(77, 20);
        add_read(20, 77, 0, 255, 1'b0);
        // widest guard, count of one: levels sit on the darkest and brightest pixels
        add_cfg(pcs_pkg::REG_PCT_COUNT, 1);
        add_cfg(pcs_pkg::REG_MIN_RANGE, 1);
        add_cfg(pcs_pkg::REG_MAX_RANGE, 255);
        add_load(0, 0);
        add_load(50, 2);
        add_load(255, pcs_pkg::FRAME_PIXELS - 1);
        add_load(100, 2);                   // same position loaded twice, last value kept
        add_read(0, 0, 0, 255, 1'b1);
        add_read(pcs_pkg::FRAME_PIXELS - 1, 255, 0, 255, 1'b1);
        add_read(2, 100, 0, 255, 1'b1);
        // new frame with a single level: empty range, then an old pixel from the kept store
        add_load(128, 3);
        add_read(3, 128, 128, 128, 1'b0);
        add_read(0, 0, 128, 128, 1'b0);
        // count of two over two pixels: the levels cross
        add_cfg(pcs_pkg::REG_PCT_COUNT, 2);
        add_load(10, 6);
        add_load(200, 7);
        add_read(6, 10, 200, 10, 1'b0);
        // a count of 4096 is never reached: levels stay at the ends
        add_cfg(pcs_pkg::REG_PCT_COUNT, 4096);
        add_load(60, 5);
        add_read(5, 60, 0, 255, 1'b1);
        // count of zero hits both end bins at once; the spare register index is ignored
        add_cfg(pcs_pkg::REG_PCT_COUNT, 0);
        add_cfg(REG_UNUSED, 8191);
        add_load(90, 8);
        add_read(8, 90, 0, 255, 1'b1);
        // range under the lower guard
        add_cfg(pcs_pkg::REG_PCT_COUNT, 1);
        add_cfg(pcs_pkg::REG_MIN_RANGE, 255);
        add_load(100, 9);
        add_load(110, 10);
        add_read(9, 100, 100, 110, 1'b0);
        // range over an upper guard of zero
        add_cfg(pcs_pkg::REG_MIN_RANGE, 1);
        add_cfg(pcs_pkg::REG_MAX_RANGE, 0);
        add_load(30, 11);
        add_load(31, 12);
        add_read(12, 31, 30, 31, 1'b0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed list, no idling on either side
        foreach (rows[r])
        begin
            if (rows[r].op == ROW_CFG)
            begin
                if (!last_cfg) settle_idle();
                write_reg(rows[r].reg_sel, rows[r].reg_val);
            end
            else
                send_item(rows[r].op == ROW_READ ? pcs_pkg::KIND_READ : pcs_pkg::KIND_LOAD,
                          rows[r].pix, rows[r].idx, rows[r].typed, rows[r].want);
            last_cfg = (rows[r].op == ROW_CFG);
        end

        // random phases: each may write new register settings and sets an idle pattern, then a few frames
        while (random_items < RANDOM_ITEMS)
        begin
            settle_idle();
            if ($urandom_range(0, 3) != 0)
            begin
                case ($urandom_range(0, 5))
                    0:       tmp = 1;
                    1:       tmp = 4096;
                    2, 3:    tmp = $urandom_range(2, 16);
                    default: tmp = $urandom_range(17, 48);
                endcase
                write_reg(pcs_pkg::REG_PCT_COUNT, tmp[pcs_pkg::CFG_DATA_W-1:0]);
            end
            if ($urandom_range(0, 3) != 0)
            begin
                case ($urandom_range(0, 4))
                    0:       tmp = 1;
                    1:       tmp = 255;
                    default: tmp = $urandom_range(1, 40);
                endcase
                write_reg(pcs_pkg::REG_MIN_RANGE, tmp[pcs_pkg::CFG_DATA_W-1:0]);
            end
            if ($urandom_range(0, 3) != 0)
            begin
                case ($urandom_range(0, 4))
                    0:       tmp = 0;
                    1:       tmp = 255;
                    2:       tmp = $urandom_range(0, 255);
                    default: tmp = $urandom_range(120, 255);
                endcase
                write_reg(pcs_pkg::REG_MAX_RANGE, tmp[pcs_pkg::CFG_DATA_W-1:0]);
            end
            case (phase % 4)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 72; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 72; end
                default: begin send_idle_pct = 21; stall_pct = 21; end
            endcase

            repeat ($urandom_range(2, 4))
            begin
                // most frames are a band of gray levels so that the guard lets the stretch in;
                // a few are tiny, and some pixels are noise or the extremes
                base = $urandom_range(0, 220);
                spread = $urandom_range(4, 160);
                n_loads = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4)
                                                      : $urandom_range(16, 96);
                n_reads = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(4, 24);
                repeat (n_loads)
                begin
                    sel = $urandom_range(0, 19);
                    if (sel == 0)
                        p = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                    else if (sel < 4)
                    begin
                        tmp = $urandom_range(0, 255);
                        p = tmp[pcs_pkg::PIX_W-1:0];
                    end
                    else
                    begin
                        tmp = base + $urandom_range(0, spread);
                        p = (tmp > 255) ? 8'd255 : tmp[pcs_pkg::PIX_W-1:0];
                    end
                    if (written_idx.size() != 0 && $urandom_range(0, 6) == 0)
                        tmp = written_idx[$urandom_range(0, written_idx.size() - 1)];
                    else
                        tmp = $urandom_range(0, pcs_pkg::FRAME_PIXELS - 1);
                    ix = tmp[pcs_pkg::IDX_W-1:0];
                    send_item(pcs_pkg::KIND_LOAD, p, ix, 1'b0, '0);
                end
                // a frame with no reads simply runs on into the next one
                repeat (n_reads)
                begin
                    tmp = written_idx[$urandom_range(0, written_idx.size() - 1)];
                    ix = tmp[pcs_pkg::IDX_W-1:0];
                    tmp = $urandom_range(0, 255);
                    send_item(pcs_pkg::KIND_READ, tmp[pcs_pkg::PIX_W-1:0], ix, 1'b0, '0);
                end
                random_items += n_loads + n_reads;
                frames_run++;
            end
            phase++;
        end

        settle_idle();
        fail_count += pending_pixels.size();
        $display("ran %0d load beats and %0d read beats; %0d results checked",
                 loads_sent, reads_sent, results_checked);
        $display("%0d random frames over %0d register settings and idle patterns, %0d errors",
                 frames_run, phase, fail_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
